/* src/rfr_pkg.sv */
// Package for the fragment reassembler: sizes, request and status codes,
// and the packed request and response transaction types.
// Depends on nothing; used by the top level and the testbench.
package rfr_pkg;

   localparam int SEQ_MODULUS    = 1024;
   localparam int WINDOW_SLOTS   = 32;
   localparam int FRAGMENT_BYTES = 64;
   localparam int ASSEMBLY_BYTES = 1024;

   localparam int ID_BITS   = 6;
   localparam int SIZE_BITS = 18;
   localparam int HDR_BITS  = ID_BITS + SIZE_BITS;

   localparam int SEQ_W   = $clog2(SEQ_MODULUS);
   localparam int SLOT_W  = $clog2(WINDOW_SLOTS);
   localparam int FRAG_W  = $clog2(FRAGMENT_BYTES);
   localparam int ASM_W   = $clog2(ASSEMBLY_BYTES);
   localparam int TOT_W   = ASM_W + 4;
   localparam int ASM_BITS = ASSEMBLY_BYTES * 8;
   localparam int FRAG_BITS = FRAGMENT_BYTES * 8;

   // request codes
   localparam logic [1:0] REQ_RECORD = 2'd0;
   localparam logic [1:0] REQ_DRAIN  = 2'd1;
   localparam logic [1:0] REQ_READ   = 2'd2;

   // record status codes
   localparam logic [1:0] ST_ACCEPT = 2'd0;
   localparam logic [1:0] ST_DUP    = 2'd1;
   localparam logic [1:0] ST_DROP   = 2'd2;
   localparam logic [1:0] ST_NONE   = 2'd3;

   typedef struct packed {
      logic [1:0]  req_type;
      logic [15:0] sequence_req;
      logic [11:0] bit_count;
      logic        short_fragment;
      logic [5:0]  byte_index;
      logic [7:0]  data_byte;
      logic        last_byte;
      logic [9:0]  read_index;
   } rfr_req_type;

   typedef struct packed {
      logic [1:0]  record_status;
      logic        message_ready;
      logic [5:0]  message_id;
      logic [17:0] declared_size;
      logic [13:0] message_bits;
      logic [7:0]  read_data;
   } rfr_rsp_type;

endpackage

/* src/rfr_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module rfr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

/* src/reliable_fragment_reassembler_top.sv */
// Top level of the fragment reassembler: slot table, drain sequencer and
// response register. Uses rfr_pkg and two rfr_ram instances.
//
// Record transaction: result registered in the cycle after acceptance, one per cycle.
// Read transaction: result from the registered assembly RAM read, via S_READ.
// Drain transaction: each slot consumed passes S_CHECK, S_COPY (skipped for a
//   slot that copies nothing) and S_END, and a missing slot ends it in S_CHECK;
//   the copy moves one byte per cycle through the payload RAM read port.
// Reset (synchronous) clears the slot occupancy, window and run state at once;
//   no clearing pass. Results cannot be stalled by the receiver.
module reliable_fragment_reassembler_top
   import rfr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  rfr_req_type req_data,
   output logic        rsp_strobe,
   output rfr_rsp_type rsp_data,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [5:0]  csr_data
);

   typedef enum logic [2:0] {S_IDLE, S_READ, S_CHECK, S_COPY, S_END} state_type;

   state_type          state_ff, state_in;
   rfr_rsp_type        rsp_ff, rsp_in;
   logic               rsp_strobe_ff, rsp_strobe_in;
   logic [5:0]         max_id_ff;

   // slot table
   logic [SEQ_W-1:0]   slot_seq_ff  [WINDOW_SLOTS];
   logic [11:0]        slot_bits_ff [WINDOW_SLOTS];
   logic               slot_fin_ff  [WINDOW_SLOTS];
   logic [WINDOW_SLOTS-1:0] slot_occ_ff;

   // window and run state
   logic               started_ff, started_in;
   logic [SEQ_W-1:0]   exp_ff, exp_in;
   logic [TOT_W-1:0]   total_ff, total_in;
   logic               discard_ff, discard_in;
   logic               latch_ff, latch_in;

   // drain working registers
   logic [SLOT_W-1:0]  dslot_ff, dslot_in;
   logic [11:0]        dbits_ff, dbits_in;
   logic               dfin_ff, dfin_in;
   logic [ASM_W-1:0]   wbase_ff, wbase_in;
   logic [FRAG_W:0]    nbytes_ff, nbytes_in;
   logic [FRAG_W:0]    cnt_ff, cnt_in;
   logic               p_valid_ff, p_valid_in;
   logic [FRAG_W-1:0]  p_idx_ff, p_idx_in;
   logic [7:0]         hdr_ff [3];

   // slot table control
   logic               meta_we, meta_clr;
   logic [SLOT_W-1:0]  meta_addr;

   // RAM ports
   logic                      pay_we;
   logic [SLOT_W+FRAG_W-1:0]  pay_waddr, pay_raddr;
   logic [7:0]                pay_rdata;
   logic                      asm_we;
   logic [ASM_W-1:0]          asm_waddr, asm_raddr;
   logic [7:0]                asm_wdata, asm_rdata;

   // combinational helpers
   logic               accept;
   logic [SEQ_W-1:0]   seq_lo, exp_eff, seq_gap;
   logic [SLOT_W-1:0]  rslot;
   logic               seq_ok;
   logic [SEQ_W-1:0]   m_seq;
   logic [11:0]        m_bits;
   logic               m_fin, m_occ;
   logic               bad_frag;
   logic [TOT_W:0]     room;
   logic [7:0]         tail_mask;
   logic [5:0]         hdr_id;

   rfr_ram #(.WIDTH(8), .DEPTH(WINDOW_SLOTS * FRAGMENT_BYTES)) u_payload (
      .clock (clock),
      .we    (pay_we),
      .waddr (pay_waddr),
      .wdata (req_data.data_byte),
      .raddr (pay_raddr),
      .rdata (pay_rdata)
   );

   rfr_ram #(.WIDTH(8), .DEPTH(ASSEMBLY_BYTES)) u_assembly (
      .clock (clock),
      .we    (asm_we),
      .waddr (asm_waddr),
      .wdata (asm_wdata),
      .raddr (asm_raddr),
      .rdata (asm_rdata)
   );

   assign accept    = start && !busy;
   assign busy      = (state_ff != S_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

   // record decode
   assign seq_lo  = req_data.sequence_req[SEQ_W-1:0];
   assign rslot   = req_data.sequence_req[SLOT_W-1:0];
   assign seq_ok  = ({1'b0, req_data.sequence_req} < 17'(SEQ_MODULUS));
   assign exp_eff = started_ff ? exp_ff : seq_lo;
   assign seq_gap = seq_lo - exp_eff;

   // one slot table read port, shared by record and drain
   assign meta_addr = (state_ff == S_IDLE) ? rslot : exp_ff[SLOT_W-1:0];
   assign m_seq  = slot_seq_ff[meta_addr];
   assign m_bits = slot_bits_ff[meta_addr];
   assign m_fin  = slot_fin_ff[meta_addr];
   assign m_occ  = slot_occ_ff[meta_addr];

   // malformed or overflowing fragment
   assign room     = (TOT_W+1)'(ASM_BITS) - {1'b0, total_ff};
   assign bad_frag = ({1'b0, m_bits} > 13'(FRAG_BITS))
                  || (!m_fin && (m_bits[2:0] != 3'd0))
                  || ((TOT_W+1)'(m_bits) > room);

   assign tail_mask = (dbits_ff[2:0] == 3'd0) ? 8'hFF
                    : 8'(8'hFF << (4'd8 - {1'b0, dbits_ff[2:0]}));
   assign hdr_id = hdr_ff[0][7:2];

   // copy pipeline write side
   assign asm_we    = p_valid_ff;
   assign asm_waddr = wbase_ff + ASM_W'(p_idx_ff);
   assign asm_wdata = ({1'b0, p_idx_ff} == nbytes_ff - 1'b1) ? (pay_rdata & tail_mask)
                                                            : pay_rdata;
   assign asm_raddr = req_data.read_index[ASM_W-1:0];
   assign pay_raddr = {dslot_ff, cnt_ff[FRAG_W-1:0]};
   assign pay_waddr = {rslot, req_data.byte_index[FRAG_W-1:0]};

   // next-state logic
   always_comb begin
      state_in      = state_ff;
      rsp_in        = '0;
      rsp_in.record_status = ST_NONE;
      rsp_strobe_in = 1'b0;
      started_in    = started_ff;
      exp_in        = exp_ff;
      total_in      = total_ff;
      discard_in    = discard_ff;
      latch_in      = latch_ff;
      dslot_in      = dslot_ff;
      dbits_in      = dbits_ff;
      dfin_in       = dfin_ff;
      wbase_in      = wbase_ff;
      nbytes_in     = nbytes_ff;
      cnt_in        = cnt_ff;
      p_valid_in    = 1'b0;
      p_idx_in      = p_idx_ff;
      meta_we       = 1'b0;
      meta_clr      = 1'b0;
      pay_we        = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               rsp_in.record_status = ST_NONE;
               unique case (req_data.req_type)
                  REQ_RECORD: begin
                     rsp_strobe_in = 1'b1;
                     rsp_in.record_status = ST_DROP;
                     if (req_data.byte_index == 6'd0) begin
                        latch_in = 1'b0;
                        if (seq_ok) begin
                           started_in = 1'b1;
                           exp_in     = exp_eff;
                           if ({1'b0, seq_gap} >= (SEQ_W+1)'(WINDOW_SLOTS)) begin
                              rsp_in.record_status = ST_DROP;
                           end else if (m_occ && (m_seq == seq_lo)) begin
                              rsp_in.record_status = ST_DUP;
                           end else begin
                              meta_we  = 1'b1;
                              latch_in = 1'b1;
                              pay_we   = 1'b1;
                              rsp_in.record_status = ST_ACCEPT;
                           end
                        end
                     end else if (latch_ff && ({1'b0, req_data.byte_index}
                                  < 7'(FRAGMENT_BYTES))) begin
                        pay_we = 1'b1;
                        rsp_in.record_status = ST_ACCEPT;
                     end
                     if (req_data.last_byte) begin
                        latch_in = 1'b0;
                     end
                  end
                  REQ_DRAIN: begin
                     if (started_ff) begin
                        state_in = S_CHECK;
                     end else begin
                        rsp_strobe_in = 1'b1;
                     end
                  end
                  REQ_READ: begin
                     state_in = S_READ;
                  end
                  default: begin
                     rsp_strobe_in = 1'b1;
                  end
               endcase
            end
         end
         S_READ: begin
            rsp_strobe_in      = 1'b1;
            rsp_in.read_data   = asm_rdata;
            state_in           = S_IDLE;
         end
         S_CHECK: begin
            if (!m_occ || (m_seq != exp_ff)) begin
               rsp_strobe_in = 1'b1;
               state_in      = S_IDLE;
            end else begin
               meta_clr   = 1'b1;
               dslot_in   = exp_ff[SLOT_W-1:0];
               dbits_in   = m_bits;
               dfin_in    = m_fin;
               discard_in = discard_ff || bad_frag;
               exp_in     = exp_ff + 1'b1;
               cnt_in     = '0;
               nbytes_in  = (FRAG_W+1)'((13'(m_bits) + 13'd7) >> 3);
               wbase_in   = total_ff[ASM_W+2:3];
               state_in   = S_END;
               if (!(discard_ff || bad_frag)) begin
                  total_in = total_ff + TOT_W'(m_bits);
                  if (m_bits != 12'd0) begin
                     state_in = S_COPY;
                  end
               end
            end
         end
         S_COPY: begin
            if (cnt_ff < nbytes_ff) begin
               p_valid_in = 1'b1;
               p_idx_in   = cnt_ff[FRAG_W-1:0];
               cnt_in     = cnt_ff + 1'b1;
            end else if (!p_valid_ff) begin
               state_in = S_END;
            end
         end
         S_END: begin
            state_in = S_CHECK;
            if (dfin_ff) begin
               total_in   = '0;
               discard_in = 1'b0;
               if (!discard_ff && (total_ff >= TOT_W'(HDR_BITS))
                   && (hdr_id <= max_id_ff)) begin
                  rsp_strobe_in        = 1'b1;
                  rsp_in.message_ready = 1'b1;
                  rsp_in.message_id    = hdr_id;
                  rsp_in.declared_size = {hdr_ff[0][1:0], hdr_ff[1], hdr_ff[2]};
                  rsp_in.message_bits  = 14'(total_ff);
                  state_in             = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         rsp_strobe_ff <= 1'b0;
         rsp_ff        <= '0;
         started_ff    <= 1'b0;
         exp_ff        <= '0;
         total_ff      <= '0;
         discard_ff    <= 1'b0;
         latch_ff      <= 1'b0;
         p_valid_ff    <= 1'b0;
         max_id_ff     <= 6'd63;
      end else begin
         state_ff      <= state_in;
         rsp_strobe_ff <= rsp_strobe_in;
         rsp_ff        <= rsp_in;
         started_ff    <= started_in;
         exp_ff        <= exp_in;
         total_ff      <= total_in;
         discard_ff    <= discard_in;
         latch_ff      <= latch_in;
         p_valid_ff    <= p_valid_in;
         if (csr_valid && csr_ready) begin
            max_id_ff <= csr_data;
         end
      end
   end

   // drain working registers and header capture
   always_ff @(posedge clock) begin
      dslot_ff  <= dslot_in;
      dbits_ff  <= dbits_in;
      dfin_ff   <= dfin_in;
      wbase_ff  <= wbase_in;
      nbytes_ff <= nbytes_in;
      cnt_ff    <= cnt_in;
      p_idx_ff  <= p_idx_in;
      if (asm_we && (asm_waddr == ASM_W'(0))) begin
         hdr_ff[0] <= asm_wdata;
      end
      if (asm_we && (asm_waddr == ASM_W'(1))) begin
         hdr_ff[1] <= asm_wdata;
      end
      if (asm_we && (asm_waddr == ASM_W'(2))) begin
         hdr_ff[2] <= asm_wdata;
      end
   end

   // slot table: occupancy resets, the rest is qualified by it
   always_ff @(posedge clock) begin
      if (reset) begin
         slot_occ_ff <= '0;
      end else if (meta_we) begin
         slot_occ_ff[meta_addr] <= 1'b1;
      end else if (meta_clr) begin
         slot_occ_ff[meta_addr] <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (meta_we) begin
         slot_seq_ff[meta_addr]  <= seq_lo;
         slot_bits_ff[meta_addr] <= req_data.bit_count;
         slot_fin_ff[meta_addr]  <= req_data.short_fragment;
      end
   end

`ifndef NO_ASSERTIONS
   // a record transaction answers in the next cycle
   a_record_rsp: assert property (@(posedge clock) disable iff (reset)
      (accept && (req_data.req_type == REQ_RECORD)) |=> rsp_strobe)
      else $error("record transaction without response");

   // copy writes only happen while copying
   a_copy_write: assert property (@(posedge clock) disable iff (reset)
      p_valid_ff |-> (state_ff == S_COPY))
      else $error("assembly write outside copy");

   // a produced message always carries a full header
   a_msg_bits: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_data.message_ready) |-> (rsp_data.message_bits >= 14'(HDR_BITS)))
      else $error("message shorter than header");

   // the response strobe returns the block to idle
   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe_in && (state_ff != S_IDLE)) |=> (state_ff == S_IDLE))
      else $error("response without return to idle");
`endif

endmodule

/* tb/tb_reliable_fragment_reassembler_top.sv */
// Self-checking testbench for reliable_fragment_reassembler_top: directed and random
// fragment, drain and read transactions, checked against an in-bench predictor.
// Depends on rfr_pkg and the top level only.
module tb_reliable_fragment_reassembler_top;
   import rfr_pkg::*;

   localparam logic [1:0] REQ_NONE = 2'd3;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   rfr_req_type req_data = '0;
   logic        rsp_strobe;
   rfr_rsp_type rsp_data;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [5:0]  csr_data = '0;

   reliable_fragment_reassembler_top u_dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // transactions waiting to go in, and the responses they must produce
   rfr_req_type pend_q[$];
   rfr_rsp_type resp_q[$];
   int          gen_count  = 0;
   int          fail_count = 0;
   int          idle_pct   = 31;
   logic        req_taken  = 1'b0;

   // predicted block state
   logic [7:0] slot_mem [WINDOW_SLOTS*FRAGMENT_BYTES];
   bit         slot_mem_ok [WINDOW_SLOTS*FRAGMENT_BYTES];
   int         slot_seq_m [WINDOW_SLOTS];
   int         slot_bits_m [WINDOW_SLOTS];
   bit         slot_fin_m [WINDOW_SLOTS];
   bit         slot_occ_m [WINDOW_SLOTS];
   logic [7:0] asm_mem [ASSEMBLY_BYTES];
   bit         asm_ok [ASSEMBLY_BYTES];
   bit         win_open;
   int         next_seq;
   int         asm_total;
   bit         run_bad;
   bit         rec_latch;
   logic [5:0] id_limit = 6'd63;

   // one record byte: window, duplicate and latch handling
   function automatic logic [1:0] predict_record(rfr_req_type r);
      int         seq;
      int         slot;
      int         gap;
      logic [1:0] st;
      seq  = int'(r.sequence_req);
      slot = seq % WINDOW_SLOTS;
      if (r.byte_index == 0) begin
         rec_latch = 1'b0;
         if (seq >= SEQ_MODULUS) begin
            st = ST_DROP;
         end else begin
            if (!win_open) begin
               win_open = 1'b1;
               next_seq = seq;
            end
            gap = (seq + SEQ_MODULUS - next_seq) % SEQ_MODULUS;
            if (gap >= WINDOW_SLOTS) begin
               st = ST_DROP;
            end else if (slot_occ_m[slot] && slot_seq_m[slot] == seq) begin
               st = ST_DUP;
            end else begin
               slot_seq_m[slot]  = seq;
               slot_bits_m[slot] = int'(r.bit_count);
               slot_fin_m[slot]  = r.short_fragment;
               slot_occ_m[slot]  = 1'b1;
               rec_latch         = 1'b1;
               slot_mem[slot*FRAGMENT_BYTES]    = r.data_byte;
               slot_mem_ok[slot*FRAGMENT_BYTES] = 1'b1;
               st = ST_ACCEPT;
            end
         end
      end else if (rec_latch) begin
         slot_mem[slot*FRAGMENT_BYTES + r.byte_index]    = r.data_byte;
         slot_mem_ok[slot*FRAGMENT_BYTES + r.byte_index] = 1'b1;
         st = ST_ACCEPT;
      end else begin
         st = ST_DROP;
      end
      if (r.last_byte)
         rec_latch = 1'b0;
      return st;
   endfunction

   // drain walk: copy slots in sequence order until a message closes or a gap
   function automatic bit predict_drain(output int id, output int size, output int total);
      int         slot;
      int         bits;
      int         nb;
      int         base;
      bit         fin;
      bit         refused;
      logic [7:0] mask;
      id = 0;
      size = 0;
      total = 0;
      if (!win_open)
         return 1'b0;
      for (int g = 0; g <= WINDOW_SLOTS; g++) begin
         slot = next_seq % WINDOW_SLOTS;
         if (!slot_occ_m[slot] || slot_seq_m[slot] != next_seq)
            return 1'b0;
         bits = slot_bits_m[slot];
         fin  = slot_fin_m[slot];
         if (bits > FRAG_BITS || (!fin && bits % 8 != 0) || bits > ASM_BITS - asm_total)
            run_bad = 1'b1;
         if (!run_bad) begin
            nb   = (bits + 7) / 8;
            base = asm_total / 8;
            for (int j = 0; j < nb; j++) begin
               asm_mem[base + j] = slot_mem[slot*FRAGMENT_BYTES + j];
               asm_ok[base + j]  = 1'b1;
            end
            asm_total += bits;
            if (asm_total % 8 != 0) begin
               mask = 8'(8'hFF << (8 - asm_total % 8));
               asm_mem[asm_total / 8] &= mask;
            end
         end
         slot_occ_m[slot]  = 1'b0;
         slot_seq_m[slot]  = 0;
         slot_bits_m[slot] = 0;
         slot_fin_m[slot]  = 1'b0;
         next_seq = (next_seq + 1) % SEQ_MODULUS;
         if (!fin)
            continue;
         refused   = run_bad;
         total     = asm_total;
         asm_total = 0;
         run_bad   = 1'b0;
         if (refused || total < HDR_BITS)
            continue;
         id = int'(asm_mem[0][7:2]);
         if (id > int'(id_limit))
            continue;
         size = int'({asm_mem[0][1:0], asm_mem[1], asm_mem[2]});
         return 1'b1;
      end
      return 1'b0;
   endfunction

   function automatic rfr_rsp_type predict_reassembly(rfr_req_type r);
      rfr_rsp_type o;
      int          id;
      int          size;
      int          bits;
      o = '0;
      o.record_status = ST_NONE;
      case (r.req_type)
         REQ_RECORD: begin
            o.record_status = predict_record(r);
         end
         REQ_DRAIN: begin
            if (predict_drain(id, size, bits)) begin
               o.message_ready = 1'b1;
               o.message_id    = 6'(id);
               o.declared_size = 18'(size);
               o.message_bits  = 14'(bits);
            end
         end
         REQ_READ: begin
            o.read_data = asm_mem[r.read_index];
         end
         default: ;
      endcase
      return o;
   endfunction

   function automatic rfr_req_type random_fields();
      logic [63:0] w;
      w = {$urandom, $urandom};
      return w[$bits(rfr_req_type)-1:0];
   endfunction

   task automatic queue_item(rfr_req_type r);
      resp_q.push_back(predict_reassembly(r));
      pend_q.push_back(r);
      gen_count++;
   endtask

   // one fragment record of at most the bytes its length needs; a short send
   // only leaves out bytes already held in the slot
   task automatic send_record(int seq, int bits, bit fin, int nsend,
                              logic [23:0] head, bit with_head);
      int          slot;
      int          need;
      bit          held;
      rfr_req_type r;
      slot = seq % WINDOW_SLOTS;
      need = (bits > FRAG_BITS) ? 1 : (bits + 7) / 8;
      if (need < 1) need = 1;
      if (nsend < 1) nsend = 1;
      if (nsend > need) nsend = need;
      held = 1'b1;
      for (int j = nsend; j < need; j++)
         if (!slot_mem_ok[slot*FRAGMENT_BYTES + j]) held = 1'b0;
      if (!held) nsend = need;
      for (int j = 0; j < nsend; j++) begin
         r = random_fields();
         r.req_type       = REQ_RECORD;
         r.sequence_req   = 16'(seq);
         r.bit_count      = 12'(bits);
         r.short_fragment = fin;
         r.byte_index     = 6'(j);
         r.last_byte      = (j == nsend - 1);
         if (with_head && j < 3)
            r.data_byte = head[23 - 8*j -: 8];
         queue_item(r);
      end
   endtask

   task automatic queue_drain();
      rfr_req_type r;
      r = random_fields();
      r.req_type = REQ_DRAIN;
      queue_item(r);
   endtask

   // reads only touch assembly bytes that have been written
   task automatic queue_read();
      int          idx;
      bit          found;
      rfr_req_type r;
      found = 1'b0;
      idx = 0;
      for (int t = 0; t < 40 && !found; t++) begin
         idx   = $urandom_range(0, ASSEMBLY_BYTES - 1);
         found = asm_ok[idx];
      end
      if (found) begin
         r = random_fields();
         r.req_type   = REQ_READ;
         r.read_index = 10'(idx);
         queue_item(r);
      end
   endtask

   // well-formed message: fragments in shuffled order, maybe a duplicate, then drain
   task automatic send_message(logic [23:0] head);
      int base;
      int n;
      int tmp;
      int k;
      int bits [3];
      int order [3];
      base = win_open ? next_seq : $urandom_range(0, SEQ_MODULUS - 1);
      n = $urandom_range(1, 3);
      for (int i = 0; i < 3; i++) begin
         order[i] = i;
         bits[i]  = (i == 0) ? $urandom_range(3, 8) * 8 : $urandom_range(1, 8) * 8;
      end
      if (n == 1)
         bits[0] = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 23)
                                               : $urandom_range(24, 64);
      else
         bits[n-1] = $urandom_range(1, 64);
      if (n > 1 && $urandom_range(0, 1)) begin
         k = $urandom_range(1, n - 1);
         tmp = order[0];
         order[0] = order[k];
         order[k] = tmp;
      end
      for (int i = 0; i < n; i++) begin
         k = order[i];
         send_record((base + k) % SEQ_MODULUS, bits[k], k == n - 1,
                     ($urandom_range(0, 9) == 0) ? 1 : 64, head, k == 0);
      end
      if ($urandom_range(0, 9) == 0)
         send_record(base, bits[0], n == 1, 64, head, 1'b1);
      queue_drain();
      repeat ($urandom_range(0, 2)) queue_read();
   endtask

   task automatic send_noise();
      rfr_req_type r;
      int          seq;
      case ($urandom_range(0, 5))
         0: begin
            seq = $urandom_range(0, 1) ? $urandom_range(0, 65535)
                                       : (next_seq + $urandom_range(0, 40)) % SEQ_MODULUS;
            send_record(seq, $urandom_range(0, 4095), $urandom_range(0, 1),
                        $urandom_range(1, 4), 24'h0, 1'b0);
         end
         1: begin
            r = random_fields();
            r.req_type = REQ_RECORD;
            if (r.byte_index == 0) r.byte_index = 1;
            queue_item(r);
         end
         2: begin
            r = random_fields();
            r.req_type = REQ_NONE;
            queue_item(r);
         end
         3: queue_drain();
         default: queue_read();
      endcase
   endtask

   task automatic fill_random(int count);
      int target;
      target = gen_count + count;
      while (gen_count < target) begin
         if ($urandom_range(0, 3) != 0)
            send_message(24'($urandom));
         else
            send_noise();
      end
   endtask

   task automatic wait_idle();
      while (pend_q.size() != 0 || resp_q.size() != 0 || busy)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_limit(logic [5:0] v);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_data  <= v;
      do @(posedge clock); while (!csr_ready);
      id_limit = v;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // sender: hold the current transaction until taken, idle at random otherwise
   always @(posedge clock)
      req_taken <= !reset && start && !busy;

   always @(negedge clock) begin : drive
      logic go;
      if (!reset) begin
         if (req_taken)
            void'(pend_q.pop_front());
         if (start && !req_taken)
            go = 1'b1;
         else
            go = pend_q.size() > 0 && ($urandom_range(0, 99) >= idle_pct);
         start <= go;
         if (go)
            req_data <= pend_q[0];
      end
   end

   // response checker
   always @(posedge clock) begin : check
      rfr_rsp_type want;
      if (!reset && rsp_strobe) begin
         if (resp_q.size() == 0) begin
            $error("response with no transaction outstanding");
            fail_count++;
         end else begin
            want = resp_q.pop_front();
            if (rsp_data.record_status !== want.record_status) begin
               $error("record_status expected %0d got %0d",
                      want.record_status, rsp_data.record_status);
               fail_count++;
            end
            if (rsp_data.message_ready !== want.message_ready) begin
               $error("message_ready expected %0d got %0d",
                      want.message_ready, rsp_data.message_ready);
               fail_count++;
            end
            if (rsp_data.message_id !== want.message_id) begin
               $error("message_id expected %0d got %0d",
                      want.message_id, rsp_data.message_id);
               fail_count++;
            end
            if (rsp_data.declared_size !== want.declared_size) begin
               $error("declared_size expected %0d got %0d",
                      want.declared_size, rsp_data.declared_size);
               fail_count++;
            end
            if (rsp_data.message_bits !== want.message_bits) begin
               $error("message_bits expected %0d got %0d",
                      want.message_bits, rsp_data.message_bits);
               fail_count++;
            end
            if (rsp_data.read_data !== want.read_data) begin
               $error("read_data expected %0d got %0d",
                      want.read_data, rsp_data.read_data);
               fail_count++;
            end
         end
      end
   end

   initial begin
      #20000000;
      $display("FAILURE");
      $finish;
   end

   initial begin
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      write_limit(6'd63);

      // directed: drain before any record, out-of-space sequence, stray byte
      idle_pct = 31;
      queue_drain();
      send_record(16'hFFFF, 12'hFFF, 1'b1, 1, 24'h0, 1'b0);
      queue_item('{req_type: REQ_RECORD, sequence_req: 16'd5, bit_count: 12'd0,
                   short_fragment: 1'b0, byte_index: 6'd63, data_byte: 8'hFF,
                   last_byte: 1'b1, read_index: 10'h3FF});
      // run that overflows the assembly store: three full slots per lap of the
      // window reused from held bytes, single bytes elsewhere, drained lap by
      // lap while wrapping the sequence space
      for (int i = 0; i < 131; i++) begin
         send_record((1000 + i) % SEQ_MODULUS,
                     (i % WINDOW_SLOTS < 3) ? FRAG_BITS : 8, 1'b0, 1,
                     24'hFFFFFF, i == 0);
         if (i % WINDOW_SLOTS == WINDOW_SLOTS - 1)
            queue_drain();
      end
      send_record((1000 + 131) % SEQ_MODULUS, 8, 1'b1, 1, 24'h0, 1'b0);
      queue_drain();
      queue_item('{req_type: REQ_READ, sequence_req: 16'd0, bit_count: 12'd0,
                   short_fragment: 1'b0, byte_index: 6'd0, data_byte: 8'h00,
                   last_byte: 1'b0, read_index: 10'd1011});
      send_noise();
      // oversized payload, then a non-final length that is not whole bytes
      send_record(next_seq, 12'hFFF, 1'b1, 1, 24'h0, 1'b0);
      queue_drain();
      send_record(next_seq, 12, 1'b0, 2, 24'h0, 1'b0);
      send_record((next_seq + 1) % SEQ_MODULUS, 16, 1'b1, 2, 24'h0, 1'b0);
      queue_drain();
      // too short for a header, outside the window, extreme headers
      send_record(next_seq, 16, 1'b1, 2, 24'hFFFFFF, 1'b1);
      queue_drain();
      send_record((next_seq + 40) % SEQ_MODULUS, 8, 1'b1, 1, 24'h0, 1'b0);
      send_message(24'hFFFFFF);
      send_message(24'h000000);
      fill_random(110);
      wait_idle();

      write_limit(6'd0);
      idle_pct = 78;
      fill_random(110);
      wait_idle();

      write_limit(6'($urandom_range(1, 62)));
      idle_pct = 0;
      fill_random(110);
      while (pend_q.size() != 0 || resp_q.size() != 0)
         @(posedge clock);
      repeat (20) @(posedge clock);
      if (fail_count == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule
